### sv/pvl_pkg.sv
// Shared types and constants for the velocity PI loop.
package pvl_pkg;

	// Default values for the top-level parameters.
	localparam int unsigned GAIN_SHIFT_DEFAULT    = 12;
	localparam int unsigned COMMAND_LIMIT_DEFAULT = 32767;

	// Field and intermediate widths.
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned LIMIT_W     = 31;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned ERR_W       = DATA_W + 1;
	localparam int unsigned PROD_W      = DATA_W + ERR_W;
	localparam int unsigned PSUM_W      = PROD_W + 2;
	localparam int unsigned ISUM_W      = PROD_W + 1;
	localparam int unsigned OSUM_W      = PSUM_W + 1;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_CFF       = 3'd2,
		REG_GAIN_DFF       = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_DRIVE_LIMIT    = 3'd5
	} cfg_reg_t;

	// Configuration register contents.
	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_cff;
		logic signed [DATA_W-1:0] gain_dff;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [LIMIT_W-1:0]       drive_limit;
	} cfg_t;

	// Input register contents.
	typedef struct packed {
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		logic signed [DATA_W-1:0] prev_target;
		logic                     run;
	} s1_t;

	// Product register contents.
	typedef struct packed {
		logic signed [PROD_W-1:0] prod_p;
		logic signed [PROD_W-1:0] prod_i;
		logic signed [PROD_W-1:0] prod_c;
		logic signed [PROD_W-1:0] prod_d;
		logic                     err_neg;
		logic                     err_pos;
		logic                     run;
	} s2_t;

	// Scaled-term register contents.
	typedef struct packed {
		logic signed [PSUM_W-1:0] p_sum;
		logic signed [PROD_W-1:0] i_term;
		logic                     err_neg;
		logic                     err_pos;
		logic                     run;
	} s3_t;

	// Status of the integrator stage, used for checking.
	typedef struct packed {
		logic loaded;
		logic run;
		logic acc_zero;
		logic out_run;
	} integ_status_t;

endpackage

### sv/pvl_input_stage.sv
// Input register. Tracks the previous command so the command change is known
// as soon as a transaction is taken.
module pvl_input_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pvl_pkg::DATA_W-1:0] target,
	input  logic signed [pvl_pkg::DATA_W-1:0] measured,
	input  logic                              run,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pvl_pkg::s1_t                      out_data
);

	logic                              valid_s1;
	pvl_pkg::s1_t                      data_s1;
	logic signed [pvl_pkg::DATA_W-1:0] last_target_q;
	logic                              was_running_q;
	logic                              accept;

	assign in_ready  = !valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// Control state and the command history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			last_target_q <= '0;
			was_running_q <= 1'b1;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				last_target_q <= target;
				was_running_q <= run;
			end
		end
	end

	// On the first running tick after a disabled one the change is zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.target      <= target;
			data_s1.measured    <= measured;
			data_s1.prev_target <= was_running_q ? last_target_q : target;
			data_s1.run         <= run;
		end
	end

endmodule

### sv/pvl_product_stage.sv
// Error, command change and the four gain products.
module pvl_product_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  pvl_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  pvl_pkg::s1_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pvl_pkg::s2_t  out_data
);

	logic                                valid_s2;
	pvl_pkg::s2_t                        data_s2;
	logic signed [pvl_pkg::ERR_W-1:0]    err;
	logic signed [pvl_pkg::ERR_W-1:0]    delta;
	logic signed [pvl_pkg::PROD_W-1:0]   prod_p;
	logic signed [pvl_pkg::PROD_W-1:0]   prod_i;
	logic signed [pvl_pkg::PROD_W-2:0]   prod_c;
	logic signed [pvl_pkg::PROD_W-1:0]   prod_d;
	logic                                accept;

	assign in_ready  = !valid_s2 || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// Differences are formed one bit wider so they never overflow.
	assign err   = pvl_pkg::ERR_W'(in_data.target) - pvl_pkg::ERR_W'(in_data.measured);
	assign delta = pvl_pkg::ERR_W'(in_data.target) - pvl_pkg::ERR_W'(in_data.prev_target);

	// Full-width signed products.
	assign prod_p = cfg.gain_p * err;
	assign prod_i = cfg.gain_i * err;
	assign prod_c = cfg.gain_cff * in_data.target;
	assign prod_d = cfg.gain_dff * delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s2.prod_p  <= prod_p;
			data_s2.prod_i  <= prod_i;
			data_s2.prod_c  <= pvl_pkg::PROD_W'(prod_c);
			data_s2.prod_d  <= prod_d;
			data_s2.err_neg <= err[pvl_pkg::ERR_W-1];
			data_s2.err_pos <= !err[pvl_pkg::ERR_W-1] && (err != '0);
			data_s2.run     <= in_data.run;
		end
	end

endmodule

### sv/pvl_sum_stage.sv
// Scales the products and adds the terms that do not involve the integrator.
module pvl_sum_stage #(
	parameter int unsigned GAIN_SHIFT = pvl_pkg::GAIN_SHIFT_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  pvl_pkg::s2_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output pvl_pkg::s3_t out_data
);

	logic                              valid_s3;
	pvl_pkg::s3_t                      data_s3;
	logic signed [pvl_pkg::PROD_W-1:0] prop;
	logic signed [pvl_pkg::PROD_W-1:0] ff_cmd;
	logic signed [pvl_pkg::PROD_W-1:0] ff_delta;
	logic signed [pvl_pkg::PROD_W-1:0] i_term;
	logic signed [pvl_pkg::PSUM_W-1:0] p_sum;
	logic                              accept;

	assign in_ready  = !valid_s3 || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	// Arithmetic shifts round toward minus infinity.
	assign prop     = in_data.prod_p >>> GAIN_SHIFT;
	assign ff_cmd   = in_data.prod_c >>> GAIN_SHIFT;
	assign ff_delta = in_data.prod_d >>> GAIN_SHIFT;
	assign i_term   = in_data.prod_i >>> GAIN_SHIFT;

	assign p_sum = pvl_pkg::PSUM_W'(prop) + pvl_pkg::PSUM_W'(ff_cmd)
	             + pvl_pkg::PSUM_W'(ff_delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s3.p_sum   <= p_sum;
			data_s3.i_term  <= i_term;
			data_s3.err_neg <= in_data.err_neg;
			data_s3.err_pos <= in_data.err_pos;
			data_s3.run     <= in_data.run;
		end
	end

endmodule

### sv/pvl_integrator.sv
// Integrator with anti-windup, output clamp and the result register.
module pvl_integrator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pvl_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pvl_pkg::s3_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pvl_pkg::DATA_W-1:0]  drive_command,
	output pvl_pkg::integ_status_t             status
);

	logic                              valid_q;
	logic signed [pvl_pkg::DATA_W-1:0] drive_q;
	logic                              out_run_q;
	logic signed [pvl_pkg::DATA_W-1:0] acc_q;
	logic                              load;

	logic signed [pvl_pkg::ISUM_W-1:0] integ_sum;
	logic signed [pvl_pkg::ISUM_W-1:0] lim_i;
	logic signed [pvl_pkg::DATA_W-1:0] integ_cand;
	logic signed [pvl_pkg::OSUM_W-1:0] out_cand;
	logic signed [pvl_pkg::OSUM_W-1:0] out_hold;
	logic signed [pvl_pkg::OSUM_W-1:0] lim_d;
	logic signed [pvl_pkg::OSUM_W-1:0] drive_sum;
	logic signed [pvl_pkg::DATA_W-1:0] drive_next;
	logic signed [pvl_pkg::DATA_W-1:0] acc_next;
	logic                              above;
	logic                              below;
	logic                              commit;

	assign in_ready      = !valid_q || out_ready;
	assign load          = in_valid && in_ready;
	assign out_valid     = valid_q;
	assign drive_command = drive_q;

	assign status.loaded   = load;
	assign status.run      = in_data.run;
	assign status.acc_zero = (acc_q == '0);
	assign status.out_run  = out_run_q;

	assign lim_i = $signed({{(pvl_pkg::ISUM_W - pvl_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});
	assign lim_d = $signed({{(pvl_pkg::OSUM_W - pvl_pkg::LIMIT_W){1'b0}}, cfg.drive_limit});

	// Integrator candidate, clamped to its limit.
	assign integ_sum = pvl_pkg::ISUM_W'(acc_q) + pvl_pkg::ISUM_W'(in_data.i_term);
	always_comb begin
		priority if (integ_sum > lim_i) begin
			integ_cand = lim_i[pvl_pkg::DATA_W-1:0];
		end else if (integ_sum < -lim_i) begin
			integ_cand = -lim_i[pvl_pkg::DATA_W-1:0];
		end else begin
			integ_cand = integ_sum[pvl_pkg::DATA_W-1:0];
		end
	end

	// The candidate is kept unless it winds the output further past its limit.
	assign out_cand = pvl_pkg::OSUM_W'(in_data.p_sum) + pvl_pkg::OSUM_W'(integ_cand);
	assign out_hold = pvl_pkg::OSUM_W'(in_data.p_sum) + pvl_pkg::OSUM_W'(acc_q);
	assign above    = out_cand > lim_d;
	assign below    = out_cand < -lim_d;
	assign commit   = (!above && !below) || (above && in_data.err_neg)
	                || (below && in_data.err_pos);
	assign acc_next  = commit ? integ_cand : acc_q;
	assign drive_sum = commit ? out_cand : out_hold;

	// Output clamp.
	always_comb begin
		priority if (drive_sum > lim_d) begin
			drive_next = lim_d[pvl_pkg::DATA_W-1:0];
		end else if (drive_sum < -lim_d) begin
			drive_next = -lim_d[pvl_pkg::DATA_W-1:0];
		end else begin
			drive_next = drive_sum[pvl_pkg::DATA_W-1:0];
		end
	end

	// Integrator state; a disabled tick clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (load) begin
				acc_q <= in_data.run ? acc_next : '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load) begin
			drive_q   <= in_data.run ? drive_next : '0;
			out_run_q <= in_data.run;
		end
	end

endmodule

### sv/pi_velocity_loop_with_feedforward.sv
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         target_velocity[31:0], measured_velocity    run_enable
// m_axis    out        drive_command[31:0]                         -
// cfg       in         write-only: cfg_wr_en, cfg_index, cfg_data  -
//
// Four register stages: input, products, scaled sums, integrator/result.
// One transaction is taken every cycle while no stage is full and stalled by
// back-pressure from m_axis.
// Reset clears the integrator, the stored previous command and all valid flags, and
// loads both limits with COMMAND_LIMIT and the gains with zero.
// Each stage holds its data while the stage after it is full and stalled.
module pi_velocity_loop_with_feedforward #(
	parameter int unsigned GAIN_SHIFT    = pvl_pkg::GAIN_SHIFT_DEFAULT,
	parameter int unsigned COMMAND_LIMIT = pvl_pkg::COMMAND_LIMIT_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// target_velocity[31:0], measured_velocity[63:32]
	input  logic [63:0]                         s_axis_tdata,
	// run_enable[0]
	input  logic [0:0]                          s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// drive_command[31:0]
	output logic [31:0]                         m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_wr_en,
	input  logic [pvl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pvl_pkg::DATA_W-1:0]          cfg_data
);

	pvl_pkg::cfg_t                     cfg_q;
	pvl_pkg::s1_t                      data_s1;
	pvl_pkg::s2_t                      data_s2;
	pvl_pkg::s3_t                      data_s3;
	pvl_pkg::integ_status_t            integ_status;
	logic                              valid_s1;
	logic                              valid_s2;
	logic                              valid_s3;
	logic                              ready_s1;
	logic                              ready_s2;
	logic                              ready_s3;
	logic signed [pvl_pkg::DATA_W-1:0] drive_command;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_cff       <= '0;
			cfg_q.gain_dff       <= '0;
			cfg_q.integral_limit <= pvl_pkg::LIMIT_W'(COMMAND_LIMIT);
			cfg_q.drive_limit    <= pvl_pkg::LIMIT_W'(COMMAND_LIMIT);
		end else if (cfg_wr_en) begin
			unique case (pvl_pkg::cfg_reg_t'(cfg_index))
				pvl_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= $signed(cfg_data);
				end
				pvl_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= $signed(cfg_data);
				end
				pvl_pkg::REG_GAIN_CFF: begin
					cfg_q.gain_cff <= $signed(cfg_data);
				end
				pvl_pkg::REG_GAIN_DFF: begin
					cfg_q.gain_dff <= $signed(cfg_data);
				end
				pvl_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[pvl_pkg::LIMIT_W-1:0];
				end
				pvl_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= cfg_data[pvl_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pvl_input_stage u_input (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.target    ($signed(s_axis_tdata[31:0])),
		.measured  ($signed(s_axis_tdata[63:32])),
		.run       (s_axis_tuser[0]),
		.out_valid (valid_s1),
		.out_ready (ready_s1),
		.out_data  (data_s1)
	);

	pvl_product_stage u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.in_data   (data_s1),
		.out_valid (valid_s2),
		.out_ready (ready_s2),
		.out_data  (data_s2)
	);

	pvl_sum_stage #(
		.GAIN_SHIFT (GAIN_SHIFT)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (ready_s2),
		.in_data   (data_s2),
		.out_valid (valid_s3),
		.out_ready (ready_s3),
		.out_data  (data_s3)
	);

	pvl_integrator u_integrator (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (valid_s3),
		.in_ready      (ready_s3),
		.in_data       (data_s3),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.drive_command (drive_command),
		.status        (integ_status)
	);

	assign m_axis_tdata = drive_command;

	// A taken input transaction always occupies the input register next cycle.
	a_input_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted input did not reach the input register");

	// A disabled tick leaves the integrator cleared.
	a_disable_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_status.loaded && !integ_status.run) |=> integ_status.acc_zero)
		else $error("integrator not cleared by a disabled tick");

	// The result of a disabled tick is zero.
	a_disable_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !integ_status.out_run) |-> (m_axis_tdata == '0))
		else $error("disabled tick produced a nonzero drive command");

endmodule
